@@ design/rv32_pkg.sv @@
// Shared opcodes, status codes and the request record for the RV32IM executor.
package rv32_pkg;
    localparam int MemBytesDefault = 4096;
    localparam int XLEN = 32;

    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;

    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [31:0] W_ECALL  = 32'h0000_0073;
    localparam logic [31:0] W_EBREAK = 32'h0010_0073;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ILLEGAL = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_ECALL   = 3'd3;
    localparam logic [2:0] ST_EBREAK  = 3'd4;

    // Serial multiply/divide unit request.
    typedef struct packed {
        logic [2:0]  f3;
        logic [31:0] a;
        logic [31:0] b;
    } md_req_t;
endpackage

@@ design/rv32_muldiv.sv @@
// Bit-serial multiplier and restoring divider, one bit per cycle.
module rv32_muldiv import rv32_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  md_req_t     req,
    output logic        done,
    output logic [31:0] result
);
    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_DONE = 3'b100
    } mstate_t;

    mstate_t     state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;      // product or {remainder, quotient}
    logic [31:0] mcand_reg, mcand_next;  // multiplicand magnitude or divisor
    logic        neg_reg, neg_next;
    logic [2:0]  f3_reg, f3_next;
    logic        zero_reg, zero_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [31:0] res_reg, res_next;

    logic        na, nb, sa, sb;
    logic [31:0] ma, mb;
    logic [32:0] psum;
    logic [32:0] trial;
    logic [63:0] sh;
    logic [63:0] prod;
    logic [31:0] q, r;

    always_comb begin
        sa = (req.f3 == 3'd1) || (req.f3 == 3'd2) || (req.f3 == 3'd4) || (req.f3 == 3'd6);
        sb = (req.f3 == 3'd1) || (req.f3 == 3'd4) || (req.f3 == 3'd6);
        na = sa && req.a[31];
        nb = sb && req.b[31];
        ma = na ? (32'd0 - req.a) : req.a;
        mb = nb ? (32'd0 - req.b) : req.b;
        psum = {1'b0, acc_reg[63:32]} + (acc_reg[0] ? {1'b0, mcand_reg} : 33'd0);
        sh = {acc_reg[62:0], 1'b0};
        trial = {1'b0, sh[63:32]} - {1'b0, mcand_reg};
        prod = neg_reg ? (64'd0 - acc_reg) : acc_reg;
        q = neg_reg ? (32'd0 - acc_reg[31:0]) : acc_reg[31:0];
        r = neg_reg ? (32'd0 - acc_reg[63:32]) : acc_reg[63:32];

        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        neg_next   = neg_reg;
        f3_next    = f3_reg;
        zero_next  = zero_reg;
        dvd_next   = dvd_reg;
        res_next   = res_reg;
        case (state_reg)
            M_IDLE: begin
                if (start) begin
                    f3_next    = req.f3;
                    acc_next   = {32'd0, ma};
                    mcand_next = mb;
                    dvd_next   = req.a;
                    zero_next  = (req.b == 32'd0);
                    cnt_next   = 6'd0;
                    if (req.f3[2]) begin
                        // remainder takes the dividend sign
                        neg_next = req.f3[1] ? na : (na ^ nb);
                    end else begin
                        neg_next = na ^ nb;
                    end
                    state_next = M_RUN;
                end
            end
            M_RUN: begin
                if (f3_reg[2]) begin
                    if (!trial[32]) begin
                        acc_next = {trial[31:0], sh[31:1], 1'b1};
                    end else begin
                        acc_next = sh;
                    end
                end else begin
                    acc_next = {psum, acc_reg[31:1]};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    state_next = M_DONE;
                end
            end
            M_DONE: begin
                case (f3_reg)
                    3'd0:    res_next = prod[31:0];
                    3'd1, 3'd2, 3'd3: res_next = prod[63:32];
                    3'd4, 3'd5: res_next = zero_reg ? 32'hFFFF_FFFF : q;
                    default: res_next = zero_reg ? dvd_reg : r;
                endcase
                state_next = M_IDLE;
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            cnt_reg   <= 6'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        neg_reg   <= neg_next;
        f3_reg    <= f3_next;
        zero_reg  <= zero_next;
        dvd_reg   <= dvd_next;
        res_reg   <= res_next;
    end

    assign done   = (state_reg == M_DONE);
    assign result = res_next;
endmodule

@@ design/rv32im_instruction_executor.sv @@
// Top level of the RV32IM executor: decode, register file, data memory and sequencer.
// ALU, branch, jump and system words pass through the read, execute, writeback and output
// states; loads and stores also pass through the memory state, and multiply and divide wait
// in the multiply/divide state for the bit-serial unit. One request is in flight at a time;
// the next can be taken in the cycle after the result is accepted.
// Reset: clear the data memory one byte per cycle, pc and registers zero.
module rv32im_instruction_executor import rv32_pkg::*; #(
    parameter int MEM_BYTES = MemBytesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instr_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic        m_reg_written,
    output logic [4:0]  m_dest_index,
    output logic signed [31:0] m_dest_value,
    output logic [2:0]  m_status
);
    localparam int AW = $clog2(MEM_BYTES);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_EXEC  = 8'b0000_1000,
        S_MEM   = 8'b0001_0000,
        S_MD    = 8'b0010_0000,
        S_WB    = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] w_reg, w_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] val_reg, val_next;
    logic [31:0] npc_reg, npc_next;
    logic [2:0]  st_reg, st_next;
    logic        wr_reg, wr_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [2:0]  bcnt_reg, bcnt_next;   // bytes moved so far
    logic [2:0]  blen_reg, blen_next;
    logic        store_reg, store_next;
    logic        rdpend_reg, rdpend_next;

    logic [31:0] rf [32];
    logic [31:0] rf_a, rf_b;
    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  mem_q;

    logic        o_wr;
    logic [4:0]  o_rd;
    logic [31:0] o_val, o_pc;
    logic [2:0]  o_st;

    // decode
    logic [6:0]  op, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, alu_b, alu_r, ea, pc4;
    logic [32:0] ea_end;
    logic        lts, ltu, take, alt;
    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd;

    md_req_t     md_req;
    logic        md_start, md_done;
    logic [31:0] md_res;

    rv32_muldiv u_md (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .req     (md_req),
        .done    (md_done),
        .result  (md_res)
    );

    always_comb begin
        op = w_reg[6:0];
        rd = w_reg[11:7];
        f3 = w_reg[14:12];
        f7 = w_reg[31:25];
        imm_i = {{20{w_reg[31]}}, w_reg[31:20]};
        imm_s = {{20{w_reg[31]}}, w_reg[31:25], w_reg[11:7]};
        imm_b = {{19{w_reg[31]}}, w_reg[31], w_reg[7], w_reg[30:25], w_reg[11:8], 1'b0};
        imm_j = {{11{w_reg[31]}}, w_reg[31], w_reg[19:12], w_reg[20], w_reg[30:21], 1'b0};
        imm_u = {w_reg[31:12], 12'd0};
        pc4 = pc_reg + 32'd4;
        alu_b = (op == OP_REG) ? b_reg : imm_i;
        alt = (op == OP_REG) ? (f7 == F7_ALT) : ((f3 == 3'd5) && (f7 == F7_ALT));
        lts = $signed(a_reg) < $signed(alu_b);
        ltu = a_reg < alu_b;
        case (f3)
            3'd0:    alu_r = alt ? a_reg - alu_b : a_reg + alu_b;
            3'd1:    alu_r = a_reg << alu_b[4:0];
            3'd2:    alu_r = {31'd0, lts};
            3'd3:    alu_r = {31'd0, ltu};
            3'd4:    alu_r = a_reg ^ alu_b;
            3'd5:    alu_r = alt ? 32'($signed(a_reg) >>> alu_b[4:0]) : a_reg >> alu_b[4:0];
            3'd6:    alu_r = a_reg | alu_b;
            default: alu_r = a_reg & alu_b;
        endcase
        case (f3)
            3'd0:    take = a_reg == b_reg;
            3'd1:    take = a_reg != b_reg;
            3'd4:    take = $signed(a_reg) < $signed(b_reg);
            3'd5:    take = !($signed(a_reg) < $signed(b_reg));
            3'd6:    take = a_reg < b_reg;
            default: take = a_reg >= b_reg;
        endcase
        ea = a_reg + ((op == OP_STORE) ? imm_s : imm_i);
        ea_end = {1'b0, ea} + {30'd0, (3'd1 << f3[1:0])};
    end

    assign md_req = '{f3: f3, a: a_reg, b: b_reg};

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pc_next     = pc_reg;
        w_next      = w_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        val_next    = val_reg;
        npc_next    = npc_reg;
        st_next     = st_reg;
        wr_next     = wr_reg;
        addr_next   = addr_reg;
        bcnt_next   = bcnt_reg;
        blen_next   = blen_reg;
        store_next  = store_reg;
        rdpend_next = 1'b0;
        md_start    = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = clr_reg;
        mem_wd      = 8'd0;
        mem_ra      = addr_reg;
        case (state_reg)
            S_CLEAR: begin
                // sweep memory to zero, one byte a cycle
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == 32'(MEM_BYTES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    w_next     = s_instr_word;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                // registered register-file reads land here
                a_next     = (w_reg[19:15] == 5'd0) ? 32'd0 : rf_a;
                b_next     = (w_reg[24:20] == 5'd0) ? 32'd0 : rf_b;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                st_next    = ST_OK;
                wr_next    = 1'b0;
                val_next   = 32'd0;
                npc_next   = pc4;
                state_next = S_WB;
                case (op)
                    OP_REG: begin
                        if (f7 == F7_MULDIV) begin
                            md_start   = 1'b1;
                            wr_next    = 1'b1;
                            state_next = S_MD;
                        end else if (f7 == 7'd0 ||
                                     (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
                            val_next = alu_r;
                            wr_next  = 1'b1;
                        end else begin
                            st_next = ST_ILLEGAL;
                        end
                    end
                    OP_IMM: begin
                        if ((f3 == 3'd1 && f7 != 7'd0) ||
                            (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT)) begin
                            st_next = ST_ILLEGAL;
                        end else begin
                            val_next = alu_r;
                            wr_next  = 1'b1;
                        end
                    end
                    OP_LOAD, OP_STORE: begin
                        if ((op == OP_LOAD && (f3 == 3'd3 || f3 > 3'd5)) ||
                            (op == OP_STORE && f3 > 3'd2)) begin
                            st_next = ST_ILLEGAL;
                        end else if (ea_end > 33'(MEM_BYTES)) begin
                            st_next = ST_RANGE;
                        end else begin
                            store_next = (op == OP_STORE);
                            wr_next    = (op == OP_LOAD);
                            addr_next  = ea[AW-1:0];
                            blen_next  = 3'd1 << f3[1:0];
                            bcnt_next  = 3'd0;
                            rdpend_next = 1'b0;
                            state_next = S_MEM;
                        end
                    end
                    OP_BRANCH: begin
                        if (f3 == 3'd2 || f3 == 3'd3) begin
                            st_next = ST_ILLEGAL;
                        end else if (take) begin
                            npc_next = pc_reg + imm_b;
                        end
                    end
                    OP_JAL: begin
                        val_next = pc4;
                        wr_next  = 1'b1;
                        npc_next = pc_reg + imm_j;
                    end
                    OP_JALR: begin
                        if (f3 != 3'd0) begin
                            st_next = ST_ILLEGAL;
                        end else begin
                            val_next = pc4;
                            wr_next  = 1'b1;
                            npc_next = (a_reg + imm_i) & ~32'd1;
                        end
                    end
                    OP_LUI: begin
                        val_next = imm_u;
                        wr_next  = 1'b1;
                    end
                    OP_AUIPC: begin
                        val_next = pc_reg + imm_u;
                        wr_next  = 1'b1;
                    end
                    OP_SYSTEM: begin
                        if (w_reg == W_ECALL) st_next = ST_ECALL;
                        else if (w_reg == W_EBREAK) st_next = ST_EBREAK;
                        else st_next = ST_ILLEGAL;
                    end
                    default: st_next = ST_ILLEGAL;
                endcase
            end
            S_MEM: begin
                // move one byte per cycle, little-endian
                if (store_reg) begin
                    mem_we    = 1'b1;
                    mem_wa    = addr_reg;
                    mem_wd    = b_reg[7:0];
                    b_next    = b_reg >> 8;
                    addr_next = addr_reg + 1'b1;
                    bcnt_next = bcnt_reg + 3'd1;
                    if (bcnt_reg + 3'd1 == blen_reg) state_next = S_WB;
                end else begin
                    rdpend_next = 1'b1;
                    if (rdpend_reg) begin
                        // shift the byte into place from the top
                        val_next  = {mem_q, val_reg[31:8]};
                        bcnt_next = bcnt_reg + 3'd1;
                    end
                    if (bcnt_reg + (rdpend_reg ? 3'd1 : 3'd0) < blen_reg) begin
                        addr_next = addr_reg + 1'b1;
                    end else begin
                        rdpend_next = 1'b0;
                        state_next  = S_WB;
                        case (blen_reg)
                            3'd1: val_next = f3[2] ? {24'd0, mem_q}
                                                   : {{24{mem_q[7]}}, mem_q};
                            3'd2: val_next = f3[2] ? {16'd0, mem_q, val_reg[31:24]}
                                                   : {{16{mem_q[7]}}, mem_q, val_reg[31:24]};
                            default: val_next = {mem_q, val_reg[31:8]};
                        endcase
                    end
                end
            end
            S_MD: begin
                if (md_done) begin
                    val_next   = md_res;
                    state_next = S_WB;
                end
            end
            S_WB: begin
                pc_next    = o_pc;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // fault and x0 filtering of the result
    always_comb begin
        o_st  = st_reg;
        o_pc  = (st_reg == ST_ILLEGAL || st_reg == ST_RANGE) ? pc_reg : npc_reg;
        o_wr  = wr_reg && (o_pc == npc_reg || st_reg == ST_OK) && (st_reg == ST_OK)
                && (rd != 5'd0);
        o_rd  = o_wr ? rd : 5'd0;
        o_val = o_wr ? val_reg : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            pc_reg     <= 32'd0;
            rdpend_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pc_reg     <= pc_next;
            rdpend_reg <= rdpend_next;
        end
        w_reg     <= w_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        val_reg   <= val_next;
        npc_reg   <= npc_next;
        st_reg    <= st_next;
        wr_reg    <= wr_next;
        addr_reg  <= addr_next;
        bcnt_reg  <= bcnt_next;
        blen_reg  <= blen_next;
        store_reg <= store_next;
    end

    // register file: cleared at reset, written in writeback; read the incoming word's sources
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) rf[i] <= 32'd0;
        end else if (state_reg == S_WB && o_wr) begin
            rf[rd] <= val_reg;
        end
        rf_a <= rf[w_next[19:15]];
        rf_b <= rf[w_next[24:20]];
    end

    // data memory
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        mem_q <= mem[mem_ra];
    end

    // result holding register
    logic [31:0] rpc_reg, rval_reg;
    logic        rwr_reg;
    logic [4:0]  rrd_reg;
    logic [2:0]  rst_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == S_WB) begin
            rpc_reg  <= o_pc;
            rwr_reg  <= o_wr;
            rrd_reg  <= o_rd;
            rval_reg <= o_val;
            rst_reg  <= o_st;
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = (state_reg == S_OUT);
    assign m_next_pc     = rpc_reg;
    assign m_reg_written = rwr_reg;
    assign m_dest_index  = rrd_reg;
    assign m_dest_value  = rval_reg;
    assign m_status      = rst_reg;
endmodule

@@ tb/rv32im_exec_checker.sv @@
// Request/result monitor with an instruction-level predictor for the RV32IM executor.
`timescale 1ns / 1ps
module rv32im_exec_checker import rv32_pkg::*; #(
    parameter int MEM_BYTES = MemBytesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_instr_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_next_pc,
    input  logic        m_reg_written,
    input  logic [4:0]  m_dest_index,
    input  logic signed [31:0] m_dest_value,
    input  logic [2:0]  m_status,
    output int          fail_count,
    output int          pending_count,
    output int          results_checked
);
    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4, F3_SRL = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
    localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_MULHSU = 3'd2, F3_MULHU = 3'd3;
    localparam logic [2:0] F3_DIV = 3'd4, F3_DIVU = 3'd5, F3_REM = 3'd6, F3_REMU = 3'd7;
    localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
    localparam logic [2:0] F3_B = 3'd0, F3_H = 3'd1, F3_W = 3'd2, F3_BU = 3'd4, F3_HU = 3'd5;

    typedef struct {
        logic [31:0] next_pc;
        logic        wr;
        logic [4:0]  idx;
        logic [31:0] val;
        logic [2:0]  st;
    } exec_result_t;

    logic [31:0] pc_q;
    logic [31:0] xreg [32];
    logic [7:0]  dmem [MEM_BYTES];
    exec_result_t expected_results[$];

    function automatic logic [31:0] alu_op(logic [2:0] f3, logic alt, logic [31:0] a,
                                           logic [31:0] b);
        case (f3)
            F3_ADD:  return alt ? a - b : a + b;
            F3_SLL:  return a << b[4:0];
            F3_SLT:  return {31'b0, $signed(a) < $signed(b)};
            F3_SLTU: return {31'b0, a < b};
            F3_XOR:  return a ^ b;
            F3_SRL:  return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    function automatic logic [31:0] muldiv_op(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
        logic [63:0] sa, sb, ua, ub, prod;
        logic signed [31:0] da, db;
        logic ovf;
        sa = {{32{a[31]}}, a};
        sb = {{32{b[31]}}, b};
        ua = {32'b0, a};
        ub = {32'b0, b};
        da = a;
        db = b;
        ovf = (a == 32'h8000_0000) && (b == 32'hffff_ffff);
        case (f3)
            F3_MUL:    begin prod = ua * ub; return prod[31:0]; end
            F3_MULH:   begin prod = sa * sb; return prod[63:32]; end
            F3_MULHSU: begin prod = sa * ub; return prod[63:32]; end
            F3_MULHU:  begin prod = ua * ub; return prod[63:32]; end
            F3_DIV: begin
                if (b == 0) return 32'hffff_ffff;
                if (ovf) return 32'h8000_0000;
                return 32'(da / db);
            end
            F3_DIVU:   return (b == 0) ? 32'hffff_ffff : a / b;
            F3_REM: begin
                if (b == 0) return a;
                if (ovf) return 32'h0;
                return 32'(da % db);
            end
            default:   return (b == 0) ? a : a % b;
        endcase
    endfunction

    function automatic logic fits(logic [31:0] addr, int n);
        return ({1'b0, addr} + 33'(n)) <= 33'(MEM_BYTES);
    endfunction

    // Execute one word against the shadow machine and return what the core must report.
    task automatic execute_word(input logic [31:0] w, output exec_result_t r);
        logic [6:0]  op, f7;
        logic [4:0]  rd;
        logic [2:0]  f3, st;
        logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, val, nxt, addr;
        logic        wr, take;
        int          n;
        op = w[6:0];
        rd = w[11:7];
        f3 = w[14:12];
        f7 = w[31:25];
        a = (w[19:15] == 0) ? 32'h0 : xreg[w[19:15]];
        b = (w[24:20] == 0) ? 32'h0 : xreg[w[24:20]];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        nxt = pc_q + 4;
        val = 0;
        st = ST_OK;
        wr = 0;
        take = 0;
        case (op)
            OP_REG: begin
                if (f7 == F7_MULDIV) begin
                    val = muldiv_op(f3, a, b); wr = 1;
                end else if (f7 == 0 || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL))) begin
                    val = alu_op(f3, f7 == F7_ALT, a, b); wr = 1;
                end else st = ST_ILLEGAL;
            end
            OP_IMM: begin
                if (f3 == F3_SLL && f7 != 0) st = ST_ILLEGAL;
                else if (f3 == F3_SRL && f7 != 0 && f7 != F7_ALT) st = ST_ILLEGAL;
                else begin
                    val = alu_op(f3, f3 == F3_SRL && f7 == F7_ALT, a, imm_i); wr = 1;
                end
            end
            OP_LOAD: begin
                if (f3 == 3 || f3 > F3_HU) st = ST_ILLEGAL;
                else begin
                    addr = a + imm_i;
                    n = 1 << f3[1:0];
                    if (!fits(addr, n)) st = ST_RANGE;
                    else begin
                        for (int i = n - 1; i >= 0; i--) val = (val << 8) | dmem[addr + i];
                        if (f3 == F3_B) val = {{24{val[7]}}, val[7:0]};
                        else if (f3 == F3_H) val = {{16{val[15]}}, val[15:0]};
                        wr = 1;
                    end
                end
            end
            OP_STORE: begin
                if (f3 > F3_W) st = ST_ILLEGAL;
                else begin
                    addr = a + imm_s;
                    n = 1 << f3;
                    if (!fits(addr, n)) st = ST_RANGE;
                    else for (int i = 0; i < n; i++) dmem[addr + i] = b[8*i +: 8];
                end
            end
            OP_BRANCH: begin
                case (f3)
                    F3_BEQ:  take = a == b;
                    F3_BNE:  take = a != b;
                    F3_BLT:  take = $signed(a) < $signed(b);
                    F3_BGE:  take = $signed(a) >= $signed(b);
                    F3_BLTU: take = a < b;
                    F3_BGEU: take = a >= b;
                    default: st = ST_ILLEGAL;
                endcase
                if (take) nxt = pc_q + imm_b;
            end
            OP_JAL: begin
                val = pc_q + 4; wr = 1; nxt = pc_q + imm_j;
            end
            OP_JALR: begin
                if (f3 != 0) st = ST_ILLEGAL;
                else begin
                    val = pc_q + 4; wr = 1; nxt = (a + imm_i) & ~32'h1;
                end
            end
            OP_LUI:   begin val = {w[31:12], 12'h0}; wr = 1; end
            OP_AUIPC: begin val = pc_q + {w[31:12], 12'h0}; wr = 1; end
            OP_SYSTEM: begin
                if (w == W_ECALL) st = ST_ECALL;
                else if (w == W_EBREAK) st = ST_EBREAK;
                else st = ST_ILLEGAL;
            end
            default: st = ST_ILLEGAL;
        endcase
        // Faults hold the pc and drop the writeback.
        if (st == ST_ILLEGAL || st == ST_RANGE) begin
            nxt = pc_q;
            wr = 0;
        end
        if (rd == 0) wr = 0;
        if (wr) xreg[rd] = val;
        else begin
            rd = 0;
            val = 0;
        end
        pc_q = nxt;
        r = '{nxt, wr, rd, val, st};
    endtask

    always @(posedge aclk) begin
        exec_result_t r, e;
        if (!aresetn) begin
            pc_q = 0;
            for (int i = 0; i < 32; i++) xreg[i] = 0;
            for (int i = 0; i < MEM_BYTES; i++) dmem[i] = 0;
            expected_results.delete();
            fail_count <= 0;
            results_checked <= 0;
        end else begin
            if (s_valid && s_ready) begin
                execute_word(s_instr_word, r);
                expected_results.insert(expected_results.size(), r);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result with nothing outstanding (next_pc %h)",
                                 $time, m_next_pc);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (m_next_pc !== e.next_pc || m_reg_written !== e.wr ||
                        m_dest_index !== e.idx || m_dest_value !== e.val ||
                        m_status !== e.st) begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch exp pc %h wr %b rd %0d val %h st %0d",
                                      " / got pc %h wr %b rd %0d val %h st %0d"}, $time,
                                     e.next_pc, e.wr, e.idx, e.val, e.st, m_next_pc,
                                     m_reg_written, m_dest_index, m_dest_value, m_status);
                        fail_count <= fail_count + 1;
                    end
                    results_checked <= results_checked + 1;
                end
            end
        end
        pending_count <= expected_results.size();
    end

    initial begin
        fail_count = 0;
        pending_count = 0;
        results_checked = 0;
    end
endmodule

@@ tb/rv32im_instruction_executor_test.sv @@
// Top of the RV32IM executor testbench: clock, reset, instruction stimulus and verdict.
`timescale 1ns / 1ps
module rv32im_instruction_executor_test;
    import rv32_pkg::*;

    localparam int MEM_BYTES = MemBytesDefault;
    localparam int RANDOM_ITEMS = 530;
    localparam int IDLE_LIMIT = 20000;   // covers the reset memory sweep with margin

    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SRL = 3'd5;
    localparam logic [2:0] F3_MULH = 3'd1, F3_MULHSU = 3'd2, F3_MULHU = 3'd3;
    localparam logic [2:0] F3_DIV = 3'd4, F3_DIVU = 3'd5, F3_REM = 3'd6, F3_REMU = 3'd7;
    localparam logic [2:0] F3_B = 3'd0, F3_W = 3'd2, F3_BEQ = 3'd0;
    localparam logic [6:0] F7_BAD = 7'h10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_instr_word = 32'h0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_next_pc;
    logic        m_reg_written;
    logic [4:0]  m_dest_index;
    logic signed [31:0] m_dest_value;
    logic [2:0]  m_status;

    int fail_count, pending_count, results_checked;
    int requests_sent = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    rv32im_instruction_executor #(.MEM_BYTES(MEM_BYTES)) DUT (.*);

    rv32im_exec_checker #(.MEM_BYTES(MEM_BYTES)) u_checker (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Encoders for the R, I, S and B instruction formats.
    function automatic logic [31:0] r_word(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
                                           logic [4:0] rs1, logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic logic [31:0] i_word(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                           logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] s_word(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                           logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] b_word(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                           logic [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    // Mostly well-formed words with random content; x1..x4 serve as in-range base pointers.
    function automatic logic [31:0] random_word();
        int pick;
        logic [4:0] rd, rs1, rs2;
        logic [2:0] f3;
        logic [6:0] f7;
        pick = $urandom_range(0, 99);
        rd = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(5, 31));
        rs1 = 5'($urandom_range(0, 31));
        rs2 = 5'($urandom_range(0, 31));
        f3 = 3'($urandom_range(0, 7));
        if (pick < 12)
            return i_word(OP_IMM, F3_ADD, 5'($urandom_range(1, 4)), 5'd0,
                          12'($urandom_range(0, 2047)));
        if (pick < 32) begin
            case ($urandom_range(0, 5))
                0, 1:    f7 = 7'h00;
                2:       f7 = F7_ALT;
                3, 4:    f7 = F7_MULDIV;
                default: f7 = 7'($urandom);
            endcase
            return r_word(f7, f3, rd, rs1, rs2);
        end
        if (pick < 47) begin
            f7 = ($urandom_range(0, 9) == 0) ? 7'($urandom) :
                 ($urandom_range(0, 1) ? F7_ALT : 7'h00);
            if (f3 == F3_SLL || f3 == F3_SRL)
                return {f7, rs2, rs1, f3, rd, OP_IMM};
            return i_word(OP_IMM, f3, rd, rs1, 12'($urandom));
        end
        if (pick < 62)
            return i_word(OP_LOAD, ($urandom_range(0, 9) == 0) ? f3 :
                          3'($urandom_range(0, 2)) | ($urandom_range(0, 2) == 0 ? 3'd4 : 3'd0),
                          rd, 5'($urandom_range(1, 4)), 12'($urandom));
        if (pick < 74)
            return s_word(($urandom_range(0, 9) == 0) ? f3 : 3'($urandom_range(0, 2)),
                          5'($urandom_range(1, 4)), rs2, 12'($urandom));
        if (pick < 82)
            return b_word(f3, rs1, rs2, 13'($urandom));
        if (pick < 86)
            return {20'($urandom), rd, OP_JAL};
        if (pick < 89)
            return i_word(OP_JALR, ($urandom_range(0, 4) == 0) ? f3 : F3_ADD, rd, rs1,
                          12'($urandom));
        if (pick < 93)
            return {20'($urandom), rd, $urandom_range(0, 1) ? OP_LUI : OP_AUIPC};
        if (pick < 95)
            return $urandom_range(0, 1) ? W_ECALL : W_EBREAK;
        return $urandom;
    endfunction

    // Present one request, hold it until taken, then sometimes go idle between bursts.
    task automatic send_request(input logic [31:0] w);
        s_valid <= 1'b1;
        s_instr_word <= w;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    endtask

    // Receiver: alternate between always-ready windows and random stalls.
    always @(posedge aclk) begin
        int phase;
        phase = int'(($time / 20) % 600);
        if (phase < 150) m_ready <= 1'b1;
        else if (phase < 450) m_ready <= ($urandom_range(0, 2) != 0);
        else m_ready <= ($urandom_range(0, 5) == 0);
    end

    // Watchdog: abort when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] directed [$];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        directed = '{
            i_word(OP_IMM, F3_ADD, 5'd1, 5'd0, 12'hfff),            // x1 = -1
            {20'h80000, 5'd2, OP_LUI},                              // x2 = most negative
            r_word(F7_MULDIV, F3_DIV, 5'd3, 5'd2, 5'd1),            // signed overflow divide
            r_word(F7_MULDIV, F3_REM, 5'd4, 5'd2, 5'd1),            // overflow remainder
            r_word(F7_MULDIV, F3_DIVU, 5'd5, 5'd1, 5'd0),           // divide by zero
            r_word(F7_MULDIV, F3_REMU, 5'd6, 5'd2, 5'd0),           // remainder by zero
            r_word(F7_MULDIV, F3_MULH, 5'd7, 5'd2, 5'd2),
            r_word(F7_MULDIV, F3_MULHSU, 5'd8, 5'd1, 5'd1),
            r_word(F7_MULDIV, F3_MULHU, 5'd9, 5'd1, 5'd1),
            i_word(OP_IMM, F3_ADD, 5'd0, 5'd1, 12'h005),            // write to x0 is dropped
            r_word(7'h00, F3_SLL, 5'd10, 5'd1, 5'd1),               // shift amount from low bits
            r_word(F7_ALT, F3_SRL, 5'd11, 5'd2, 5'd1),
            {F7_BAD, 5'd3, 5'd1, F3_SRL, 5'd12, OP_IMM},            // bad shift-immediate upper
            {20'h00001, 5'd13, OP_LUI},                             // x13 = MEM_BYTES
            s_word(F3_W, 5'd13, 5'd1, 12'hffc),                     // word store that just fits
            i_word(OP_LOAD, F3_W, 5'd14, 5'd13, 12'hffc),
            i_word(OP_LOAD, F3_W, 5'd15, 5'd13, 12'hffd),           // one byte past the end
            s_word(F3_B, 5'd13, 5'd1, 12'h000),                     // store past the end
            i_word(OP_LOAD, F3_B, 5'd16, 5'd13, 12'hfff),           // sign-extended byte
            W_ECALL,
            W_EBREAK,
            32'h0000_0000,
            32'hffff_ffff,
            b_word(F3_BEQ, 5'd0, 5'd0, 13'h1ff8),                   // taken backward branch
            i_word(OP_JALR, F3_ADD, 5'd17, 5'd1, 12'h002)           // target bit 0 cleared
        };
        foreach (directed[i]) send_request(directed[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Drain the core completely once, midway through the random part.
            if (i == RANDOM_ITEMS / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_count != 0) @(posedge aclk);
            end
            send_request(random_word());
        end
        s_valid <= 1'b0;

        // Wait for the remaining results, then let a slow divide worth of cycles go by.
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        $display("Sent %0d instruction words (directed edge cases plus random programs),",
                 requests_sent);
        $display("checked %0d results, %0d mismatches.", results_checked, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
